// ===== sv/minmod_flux_limited_advection_core_defines.svh =====
// Assertion macros shared by the advection core.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MINMOD_FLUX_LIMITED_ADVECTION_CORE_DEFINES_SVH
`define MINMOD_FLUX_LIMITED_ADVECTION_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define MFA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mfa: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define MFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mfa: next-cycle check failed");

`endif

// ===== sv/mfa_pkg.sv =====
// Shared widths, constants and types of the minmod advection core.
// No dependencies.
package mfa_pkg;

    localparam int VALUE_BITS        = 32;
    localparam int COURANT_FRAC_BITS = 16;

    localparam int COURANT_W = COURANT_FRAC_BITS + 2;
    localparam int CMAG_W    = COURANT_FRAC_BITS + 2;
    localparam int FMAG_W    = COURANT_FRAC_BITS + 1;
    localparam int PROD1_W   = FMAG_W + VALUE_BITS;
    localparam int FACE_W    = VALUE_BITS + 2;
    localparam int DMAG_W    = VALUE_BITS + 1;
    localparam int PROD2_W   = CMAG_W + DMAG_W;
    localparam int UPD_W     = PROD2_W - COURANT_FRAC_BITS;
    localparam int NEW_W     = VALUE_BITS + 4;

    localparam int NUM_STAGES = 6;

    // One in the Courant scale, and the rounding halves of both products.
    localparam logic [CMAG_W-1:0]  ONE_C =
        {{(CMAG_W-1){1'b0}}, 1'b1} << COURANT_FRAC_BITS;
    localparam logic [PROD1_W-1:0] HALF1 =
        {{(PROD1_W-1){1'b0}}, 1'b1} << COURANT_FRAC_BITS;
    localparam logic [PROD2_W-1:0] HALF2 =
        {{(PROD2_W-1){1'b0}}, 1'b1} << (COURANT_FRAC_BITS - 1);

    typedef logic [VALUE_BITS-1:0]       value_t;
    typedef logic signed [COURANT_W-1:0] courant_t;

    // Limited slope in sign and magnitude form.
    typedef struct packed {
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
    } slope_t;

endpackage

// ===== sv/mfa_slope.sv =====
// Minmod slope of a three-value stencil, in sign and magnitude form.
// Depends on mfa_pkg.
module mfa_slope (
    input  mfa_pkg::value_t x,
    input  mfa_pkg::value_t y,
    input  mfa_pkg::value_t z,
    output mfa_pkg::slope_t slope
);
    import mfa_pkg::*;

    logic signed [VALUE_BITS:0] d1;
    logic signed [VALUE_BITS:0] d2;
    logic signed [VALUE_BITS:0] n1;
    logic signed [VALUE_BITS:0] n2;
    logic [VALUE_BITS-1:0]      m1;
    logic [VALUE_BITS-1:0]      m2;
    logic                       both_pos;
    logic                       both_neg;

    always_comb
    begin
        d1 = $signed({1'b0, y}) - $signed({1'b0, x});
        d2 = $signed({1'b0, z}) - $signed({1'b0, y});
        n1 = -d1;
        n2 = -d2;
        m1 = d1[VALUE_BITS] ? n1[VALUE_BITS-1:0] : d1[VALUE_BITS-1:0];
        m2 = d2[VALUE_BITS] ? n2[VALUE_BITS-1:0] : d2[VALUE_BITS-1:0];
        both_pos = !d1[VALUE_BITS] && (d1 != '0) && !d2[VALUE_BITS] && (d2 != '0);
        both_neg = d1[VALUE_BITS] && d2[VALUE_BITS];

        // The smaller magnitude wins when both differences agree in sign.
        slope.neg = both_neg;
        if (both_pos || both_neg)
        begin
            slope.mag = (m1 < m2) ? m1 : m2;
        end
        else
        begin
            slope.mag = '0;
        end
    end

endmodule

// ===== sv/minmod_flux_limited_advection_core.sv =====
// Top level of the minmod-limited upwind advection core: a six-stage pipeline.
// Depends on mfa_pkg, mfa_slope and minmod_flux_limited_advection_core_defines.svh.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_stall, five values, courant  | request in
//  output  | out_valid, out_stall, new_value, saturated| request out
//
// One request enters per cycle unless in_stall is high; results pass every stage.
// The depth is set by the two multipliers, each followed by its own rounding stage.
// Reset (rst_n, asynchronous, active low) empties every stage; no payload is cleared.
// A stalled output holds its result; earlier stages keep filling bubbles, and the
// input stalls only when every stage holds a request.
module minmod_flux_limited_advection_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  mfa_pkg::value_t    far_left_value,
    input  mfa_pkg::value_t    left_value,
    input  mfa_pkg::value_t    center_value,
    input  mfa_pkg::value_t    right_value,
    input  mfa_pkg::value_t    far_right_value,
    input  mfa_pkg::courant_t  courant,
    output logic               out_valid,
    input  logic               out_stall,
    output mfa_pkg::value_t    new_value,
    output logic               saturated
);
    import mfa_pkg::*;

    `include "minmod_flux_limited_advection_core_defines.svh"

    // Stage valid bits, one per register stage; the last one is the output register.
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] adv;

    // A stage loads when it is empty or when the stage after it moves on.
    always_comb
    begin
        adv[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || !out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        vld_next[0] = adv[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = vld_reg[NUM_STAGES-1];

    // ------------------------------------------------------------------
    // Stage 1: Courant magnitude, limiter factor (1 - |c|), upwind stencil
    // selection and the two minmod slopes.
    // ------------------------------------------------------------------
    courant_t            neg_c;
    logic                s1_cneg_next;
    logic [CMAG_W-1:0]   s1_cmag_next;
    logic                s1_pos_next;
    logic                s1_fneg_next;
    logic [CMAG_W-1:0]   fmag_full;
    logic [FMAG_W-1:0]   s1_fmag_next;
    value_t              rx, ry, rz, lx, ly, lz;
    slope_t              s1_slope_r_next;
    slope_t              s1_slope_l_next;

    always_comb
    begin
        neg_c        = -courant;
        s1_cneg_next = courant[COURANT_W-1];
        s1_cmag_next = s1_cneg_next ? CMAG_W'(neg_c) : CMAG_W'(courant);
        s1_pos_next  = !s1_cneg_next && (courant != '0);
        s1_fneg_next = s1_cmag_next > ONE_C;
        fmag_full    = s1_fneg_next ? (s1_cmag_next - ONE_C) : (ONE_C - s1_cmag_next);
        s1_fmag_next = fmag_full[FMAG_W-1:0];

        // Positive flow looks left, otherwise right; the base is the middle value.
        if (s1_pos_next)
        begin
            rx = left_value;
            ry = center_value;
            rz = right_value;
            lx = far_left_value;
            ly = left_value;
            lz = center_value;
        end
        else
        begin
            rx = center_value;
            ry = right_value;
            rz = far_right_value;
            lx = left_value;
            ly = center_value;
            lz = right_value;
        end
    end

    mfa_slope u_slope_r (
        .x     (rx),
        .y     (ry),
        .z     (rz),
        .slope (s1_slope_r_next)
    );

    mfa_slope u_slope_l (
        .x     (lx),
        .y     (ly),
        .z     (lz),
        .slope (s1_slope_l_next)
    );

    logic                s1_cneg_reg;
    logic [CMAG_W-1:0]   s1_cmag_reg;
    logic                s1_pos_reg;
    logic                s1_fneg_reg;
    logic [FMAG_W-1:0]   s1_fmag_reg;
    slope_t              s1_slope_r_reg;
    slope_t              s1_slope_l_reg;
    value_t              s1_base_r_reg;
    value_t              s1_base_l_reg;
    value_t              s1_center_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_cneg_reg    <= s1_cneg_next;
            s1_cmag_reg    <= s1_cmag_next;
            s1_pos_reg     <= s1_pos_next;
            s1_fneg_reg    <= s1_fneg_next;
            s1_fmag_reg    <= s1_fmag_next;
            s1_slope_r_reg <= s1_slope_r_next;
            s1_slope_l_reg <= s1_slope_l_next;
            s1_base_r_reg  <= ry;
            s1_base_l_reg  <= ly;
            s1_center_reg  <= center_value;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: factor times slope magnitude for both faces. The face adds or
    // subtracts the correction depending on flow direction and its sign.
    // ------------------------------------------------------------------
    logic [PROD1_W-1:0] s2_prod_r_next;
    logic [PROD1_W-1:0] s2_prod_l_next;
    logic               s2_sub_r_next;
    logic               s2_sub_l_next;

    always_comb
    begin
        s2_prod_r_next = s1_fmag_reg * s1_slope_r_reg.mag;
        s2_prod_l_next = s1_fmag_reg * s1_slope_l_reg.mag;
        s2_sub_r_next  = s1_fneg_reg ^ s1_slope_r_reg.neg ^ !s1_pos_reg;
        s2_sub_l_next  = s1_fneg_reg ^ s1_slope_l_reg.neg ^ !s1_pos_reg;
    end

    logic [PROD1_W-1:0] s2_prod_r_reg;
    logic [PROD1_W-1:0] s2_prod_l_reg;
    logic               s2_sub_r_reg;
    logic               s2_sub_l_reg;
    value_t             s2_base_r_reg;
    value_t             s2_base_l_reg;
    logic               s2_cneg_reg;
    logic [CMAG_W-1:0]  s2_cmag_reg;
    value_t             s2_center_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_prod_r_reg <= s2_prod_r_next;
            s2_prod_l_reg <= s2_prod_l_next;
            s2_sub_r_reg  <= s2_sub_r_next;
            s2_sub_l_reg  <= s2_sub_l_next;
            s2_base_r_reg <= s1_base_r_reg;
            s2_base_l_reg <= s1_base_l_reg;
            s2_cneg_reg   <= s1_cneg_reg;
            s2_cmag_reg   <= s1_cmag_reg;
            s2_center_reg <= s1_center_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: round the corrections to nearest (ties away from zero, on the
    // magnitude) and form the interface values.
    // ------------------------------------------------------------------
    logic [PROD1_W-1:0]        sum_r;
    logic [PROD1_W-1:0]        sum_l;
    value_t                    corr_r;
    value_t                    corr_l;
    logic signed [FACE_W-1:0]  s3_hr_next;
    logic signed [FACE_W-1:0]  s3_hl_next;

    always_comb
    begin
        sum_r  = s2_prod_r_reg + HALF1;
        sum_l  = s2_prod_l_reg + HALF1;
        corr_r = sum_r[PROD1_W-1:COURANT_FRAC_BITS+1];
        corr_l = sum_l[PROD1_W-1:COURANT_FRAC_BITS+1];
        if (s2_sub_r_reg)
        begin
            s3_hr_next = $signed({2'b00, s2_base_r_reg}) - $signed({2'b00, corr_r});
        end
        else
        begin
            s3_hr_next = $signed({2'b00, s2_base_r_reg}) + $signed({2'b00, corr_r});
        end
        if (s2_sub_l_reg)
        begin
            s3_hl_next = $signed({2'b00, s2_base_l_reg}) - $signed({2'b00, corr_l});
        end
        else
        begin
            s3_hl_next = $signed({2'b00, s2_base_l_reg}) + $signed({2'b00, corr_l});
        end
    end

    logic signed [FACE_W-1:0] s3_hr_reg;
    logic signed [FACE_W-1:0] s3_hl_reg;
    logic                     s3_cneg_reg;
    logic [CMAG_W-1:0]        s3_cmag_reg;
    value_t                   s3_center_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_hr_reg     <= s3_hr_next;
            s3_hl_reg     <= s3_hl_next;
            s3_cneg_reg   <= s2_cneg_reg;
            s3_cmag_reg   <= s2_cmag_reg;
            s3_center_reg <= s2_center_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: flux difference across the cell, split into sign and magnitude.
    // ------------------------------------------------------------------
    logic signed [FACE_W-1:0] dh;
    logic signed [FACE_W-1:0] ndh;
    logic [DMAG_W-1:0]        s4_dmag_next;
    logic                     s4_sneg_next;

    always_comb
    begin
        dh           = s3_hr_reg - s3_hl_reg;
        ndh          = -dh;
        s4_dmag_next = dh[FACE_W-1] ? ndh[DMAG_W-1:0] : dh[DMAG_W-1:0];
        s4_sneg_next = s3_cneg_reg ^ dh[FACE_W-1];
    end

    logic [DMAG_W-1:0] s4_dmag_reg;
    logic              s4_sneg_reg;
    logic [CMAG_W-1:0] s4_cmag_reg;
    value_t            s4_center_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s4_dmag_reg   <= s4_dmag_next;
            s4_sneg_reg   <= s4_sneg_next;
            s4_cmag_reg   <= s3_cmag_reg;
            s4_center_reg <= s3_center_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: Courant magnitude times flux difference magnitude.
    // ------------------------------------------------------------------
    logic [PROD2_W-1:0] s5_prod_next;
    logic [PROD2_W-1:0] s5_prod_reg;
    logic               s5_sneg_reg;
    value_t             s5_center_reg;

    assign s5_prod_next = s4_cmag_reg * s4_dmag_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s5_prod_reg   <= s5_prod_next;
            s5_sneg_reg   <= s4_sneg_reg;
            s5_center_reg <= s4_center_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: round the update, apply it to the center value and clamp.
    // A negative update term adds to the center value.
    // ------------------------------------------------------------------
    logic [PROD2_W-1:0]       sum2;
    logic [UPD_W-1:0]         upd;
    logic signed [NEW_W-1:0]  nv;
    value_t                   new_value_next;
    logic                     saturated_next;

    always_comb
    begin
        sum2 = s5_prod_reg + HALF2;
        upd  = sum2[PROD2_W-1:COURANT_FRAC_BITS];
        if (s5_sneg_reg)
        begin
            nv = $signed({{(NEW_W-VALUE_BITS){1'b0}}, s5_center_reg})
               + $signed({{(NEW_W-UPD_W){1'b0}}, upd});
        end
        else
        begin
            nv = $signed({{(NEW_W-VALUE_BITS){1'b0}}, s5_center_reg})
               - $signed({{(NEW_W-UPD_W){1'b0}}, upd});
        end

        if (nv[NEW_W-1])
        begin
            new_value_next = '0;
            saturated_next = 1'b1;
        end
        else if (|nv[NEW_W-2:VALUE_BITS])
        begin
            new_value_next = '1;
            saturated_next = 1'b1;
        end
        else
        begin
            new_value_next = nv[VALUE_BITS-1:0];
            saturated_next = 1'b0;
        end
    end

    value_t new_value_reg;
    logic   saturated_reg;

    always_ff @(posedge clk)
    begin
        if (adv[NUM_STAGES-1])
        begin
            new_value_reg <= new_value_next;
            saturated_reg <= saturated_next;
        end
    end

    assign new_value = new_value_reg;
    assign saturated = saturated_reg;

    // ------------------------------------------------------------------
    // Checks on the pipeline control and the clamp.
    // ------------------------------------------------------------------

    // The input only stalls when every stage holds a request.
    `MFA_ASSERT_NOW(a_stall_only_when_full, in_stall, &vld_reg)

    // A request in the last compute stage reaches the output when it is free.
    `MFA_ASSERT_NEXT(a_last_stage_drains, vld_reg[NUM_STAGES-2] && !out_stall, out_valid)

    // A clamped result sits on one of the two range limits.
    `MFA_ASSERT_NOW(a_clamp_at_limit, out_valid && saturated,
                    (new_value == '0) || (new_value == '1))

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the minmod-limited upwind advection core.
// Depends directly on mfa_pkg and minmod_flux_limited_advection_core only.

module tb;

    import mfa_pkg::*;

    localparam int     FRAC_BITS      = COURANT_FRAC_BITS;
    localparam longint VALUE_MAX      = (longint'(1) <<< VALUE_BITS) - 1;
    localparam value_t VMAX           = '1;
    localparam int     ONE_Q          = 1 << FRAC_BITS;
    localparam int     RANDOM_ITEMS   = 1700;
    localparam int     IDLE_LIMIT     = 2000;
    localparam int     PRESSURE_AFTER = 400;
    localparam int     PRESSURE_LEN   = 120;
    localparam int     DRAIN_CYCLES   = 4 * NUM_STAGES;

    // Receiver stall patterns and the shapes of random stencil windows.
    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;
    typedef enum {PROFILE_RAMP, PROFILE_NOISE, PROFILE_EXTREME} profile_t;

    // One expected result of the core.
    typedef struct packed {
        value_t nv;
        logic   sat;
    } cell_update_t;

    // One row of the directed table. When typed is set, the expected result is
    // taken from the row itself instead of from the predictor.
    typedef struct {
        value_t   fl;
        value_t   l;
        value_t   c0;
        value_t   r;
        value_t   fr;
        courant_t cr;
        bit       typed;
        value_t   nv;
        bit       sat;
    } stencil_row_t;

    // Clock, reset and every input of the core start at known values.
    logic     clk             = 1'b0;
    logic     rst_n           = 1'b0;
    logic     in_valid        = 1'b0;
    logic     out_stall       = 1'b0;
    value_t   far_left_value  = '0;
    value_t   left_value      = '0;
    value_t   center_value    = '0;
    value_t   right_value     = '0;
    value_t   far_right_value = '0;
    courant_t courant         = '0;
    logic     in_stall;
    logic     out_valid;
    value_t   new_value;
    logic     saturated;

    // Tag that travels with the request currently offered: a typed expectation.
    bit       req_typed     = 1'b0;
    value_t   req_typed_nv  = '0;
    bit       req_typed_sat = 1'b0;

    cell_update_t pending_updates[$];
    stencil_row_t directed_rows[$];

    int error_count    = 0;
    int accepted_in    = 0;
    int checked_out    = 0;
    int clamped_out    = 0;
    int directed_count = 0;

    always #2 clk = ~clk;

    minmod_flux_limited_advection_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .far_left_value  (far_left_value),
        .left_value      (left_value),
        .center_value    (center_value),
        .right_value     (right_value),
        .far_right_value (far_right_value),
        .courant         (courant),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .new_value       (new_value),
        .saturated       (saturated)
    );

    // Signed round(k * v / 2^s). Rounding works on the magnitude, half away from
    // zero, and the sign of the product is put back afterwards.
    function automatic longint round_scaled(input longint k, input longint v, input int s);
        longint mag;
        longint rounded;
        if (k == 0 || v == 0)
            return 0;
        mag     = (k < 0 ? -k : k) * (v < 0 ? -v : v);
        rounded = (mag + (longint'(1) <<< (s - 1))) >>> s;
        return ((k < 0) != (v < 0)) ? -rounded : rounded;
    endfunction

    // Minmod of the two one-sided differences around y: zero unless both have
    // the same strict sign, otherwise the one with the smaller magnitude.
    function automatic longint limited_slope(input longint x, input longint y, input longint z);
        longint d1;
        longint d2;
        d1 = y - x;
        d2 = z - y;
        if (d1 > 0 && d2 > 0)
            return (d1 < d2) ? d1 : d2;
        if (d1 < 0 && d2 < 0)
            return (d1 > d2) ? d1 : d2;
        return 0;
    endfunction

    // Interface value of the stencil (x, y, z) around its base y. The slope is
    // scaled by (1 - |c|) / 2 and added on the left-upwind side, subtracted
    // on the right-upwind side.
    function automatic longint face_value(input longint x, input longint y, input longint z,
                                          input longint factor, input bit upwind_left);
        longint corr;
        corr = round_scaled(factor, limited_slope(x, y, z), FRAC_BITS + 1);
        return upwind_left ? y + corr : y - corr;
    endfunction

    // Conservative update of the center value, clamped to the value range.
    function automatic cell_update_t advect_cell(input value_t fl, input value_t l,
                                                 input value_t c0, input value_t r,
                                                 input value_t fr, input courant_t cr);
        longint       cn;
        longint       factor;
        longint       h_right;
        longint       h_left;
        longint       upd;
        cell_update_t res;
        cn     = longint'(cr);
        factor = longint'(ONE_Q) - (cn < 0 ? -cn : cn);
        if (cn > 0)
        begin
            h_right = face_value(longint'(l), longint'(c0), longint'(r), factor, 1'b1);
            h_left  = face_value(longint'(fl), longint'(l), longint'(c0), factor, 1'b1);
        end
        else
        begin
            h_right = face_value(longint'(c0), longint'(r), longint'(fr), factor, 1'b0);
            h_left  = face_value(longint'(l), longint'(c0), longint'(r), factor, 1'b0);
        end
        upd = longint'(c0) - round_scaled(cn, h_right - h_left, FRAC_BITS);
        if (upd < 0)
        begin
            res.nv  = '0;
            res.sat = 1'b1;
        end
        else if (upd > VALUE_MAX)
        begin
            res.nv  = VMAX;
            res.sat = 1'b1;
        end
        else
        begin
            res.nv  = value_t'(upd);
            res.sat = 1'b0;
        end
        return res;
    endfunction

    task automatic add_row(input value_t fl, input value_t l, input value_t c0,
                           input value_t r, input value_t fr, input int c,
                           input bit typed, input value_t nv, input bit sat);
        stencil_row_t row;
        row.fl    = fl;
        row.l     = l;
        row.c0    = c0;
        row.r     = r;
        row.fr    = fr;
        row.cr    = courant_t'(c);
        row.typed = typed;
        row.nv    = nv;
        row.sat   = sat;
        directed_rows.push_back(row);
    endtask

    // Drives one request and waits for the edge at which it is accepted. The
    // payload only changes here, so it stays put while the core stalls it.
    task automatic offer_request(input value_t fl, input value_t l, input value_t c0,
                                 input value_t r, input value_t fr, input courant_t cr,
                                 input bit typed, input value_t nv, input bit sat);
        far_left_value  <= fl;
        left_value      <= l;
        center_value    <= c0;
        right_value     <= r;
        far_right_value <= fr;
        courant         <= cr;
        req_typed       <= typed;
        req_typed_nv    <= nv;
        req_typed_sat   <= sat;
        in_valid        <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Draws one random stencil window. Ramps are the well-formed case where the
    // limiter actually produces a slope; noise and extremes exercise the
    // sign tests, the wide intermediates and the clamp.
    task automatic draw_window(output value_t fl, output value_t l, output value_t c0,
                               output value_t r, output value_t fr, output courant_t cr);
        value_t      w[5];
        profile_t    shape;
        int unsigned span;
        int unsigned pick;
        bit          rising;
        pick = $urandom_range(9);
        if (pick < 5)
            shape = PROFILE_RAMP;
        else if (pick < 8)
            shape = PROFILE_NOISE;
        else
            shape = PROFILE_EXTREME;
        case (shape)
            PROFILE_RAMP:
            begin
                span   = 32'd1 << $urandom_range(31);
                rising = 1'($urandom_range(1));
                w[0]   = $urandom;
                for (int k = 1; k < 5; k++)
                    w[k] = rising ? w[k-1] + value_t'($urandom_range(span))
                                  : w[k-1] - value_t'($urandom_range(span));
                // Now and then a kink, so that minmod sees disagreeing signs.
                if ($urandom_range(3) == 0)
                    w[$urandom_range(4)] = $urandom;
            end
            PROFILE_NOISE:
            begin
                for (int k = 0; k < 5; k++)
                    w[k] = $urandom;
            end
            default:
            begin
                for (int k = 0; k < 5; k++)
                begin
                    case ($urandom_range(4))
                        0:       w[k] = '0;
                        1:       w[k] = VMAX;
                        2:       w[k] = 32'd1;
                        3:       w[k] = VMAX - 1;
                        default: w[k] = $urandom;
                    endcase
                end
            end
        endcase
        fl = w[0];
        l  = w[1];
        c0 = w[2];
        r  = w[3];
        fr = w[4];

        // Courant: mostly the nominal range, some tiny values and exact
        // extremes, and a few beyond one, where (1 - |c|) turns negative.
        pick = $urandom_range(19);
        if (pick < 12)
            cr = courant_t'(int'($urandom_range(2 * ONE_Q)) - ONE_Q);
        else if (pick < 15)
            cr = courant_t'(int'($urandom_range(512)) - 256);
        else if (pick < 17)
        begin
            case ($urandom_range(3))
                0:       cr = courant_t'(ONE_Q);
                1:       cr = courant_t'(-ONE_Q);
                2:       cr = courant_t'(1);
                default: cr = courant_t'(-1);
            endcase
        end
        else if (pick == 17)
            cr = '0;
        else
            cr = courant_t'($urandom);
    endtask

    // Monitor: every accepted result is checked against the oldest expectation,
    // and every accepted request adds its expectation. Both sides are sampled
    // at the clock edge, before anything driven at that edge takes effect.
    always @(posedge clk)
    begin
        cell_update_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_updates.size() == 0)
                begin
                    $display("%0t: result with no request pending: new_value %h saturated %b",
                             $time, new_value, saturated);
                    error_count++;
                end
                else
                begin
                    want = pending_updates.pop_front();
                    if (new_value !== want.nv)
                    begin
                        $display("%0t: new_value mismatch: expected %h actual %h",
                                 $time, want.nv, new_value);
                        error_count++;
                    end
                    if (saturated !== want.sat)
                    begin
                        $display("%0t: saturated mismatch: expected %b actual %b",
                                 $time, want.sat, saturated);
                        error_count++;
                    end
                    if (want.sat)
                        clamped_out++;
                end
                checked_out++;
            end
            if (in_valid && !in_stall)
            begin
                if (req_typed)
                begin
                    want.nv  = req_typed_nv;
                    want.sat = req_typed_sat;
                end
                else
                begin
                    want = advect_cell(far_left_value, left_value, center_value,
                                       right_value, far_right_value, courant);
                end
                pending_updates.push_back(want);
                accepted_in++;
            end
        end
    end

    // Receiver: runs through segments of different stall patterns, including
    // segments with no stall at all. Once, after a few hundred requests, it
    // holds off for a long stretch so that the pipeline fills and the input
    // side has to stall while the sender keeps offering.
    initial
    begin : receiver
        stall_mode_t mode;
        int          seg_len;
        bit          held_off;
        held_off = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!held_off && accepted_in >= PRESSURE_AFTER)
            begin
                held_off = 1'b1;
                for (int k = 0; k < PRESSURE_LEN; k++)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            else
            begin
                mode    = stall_mode_t'($urandom_range(3));
                seg_len = $urandom_range(10, 60);
                for (int k = 0; k < seg_len; k++)
                begin
                    case (mode)
                        STALL_NONE:   out_stall <= 1'b0;
                        STALL_LIGHT:  out_stall <= ($urandom_range(9) < 3);
                        STALL_HEAVY:  out_stall <= ($urandom_range(9) < 7);
                        STALL_TOGGLE: out_stall <= k[0];
                        default:      out_stall <= 1'b0;
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Watchdog: counts consecutive cycles in which neither channel moves a
    // request and ends the run when the count reaches its limit.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    // Sender: reset, then the directed table, then random windows, all offered
    // in bursts of random length with random gaps between them.
    initial
    begin : sender
        int       burst_left;
        int       gap;
        value_t   fl, l, c0, r, fr;
        courant_t cr;

        // Values are Q8.24, so 32'h0100_0000 is one unit.
        // Zero courant leaves the center untouched; flat windows never move.
        add_row('0, '0, '0, '0, '0, 0, 1'b1, '0, 1'b0);
        add_row(VMAX, VMAX, VMAX, VMAX, VMAX, ONE_Q, 1'b1, VMAX, 1'b0);
        add_row(32'd1, 32'd2, VMAX, 32'd3, 32'd4, 0, 1'b1, VMAX, 1'b0);
        // At a courant of exactly one the limiter term vanishes and the cell
        // takes its upwind neighbor.
        add_row(VMAX, 32'h1234_5678, '0, VMAX, '0, ONE_Q, 1'b1, 32'h1234_5678, 1'b0);
        add_row('0, '0, VMAX, 32'h0ABC_DEF0, VMAX, -ONE_Q, 1'b1, 32'h0ABC_DEF0, 1'b0);
        // Courant near two with a step: the update overshoots both ends.
        add_row(VMAX, VMAX, '0, '0, '0, 2 * ONE_Q - 1, 1'b1, VMAX, 1'b1);
        add_row('0, VMAX, VMAX, '0, '0, -2 * ONE_Q, 1'b1, '0, 1'b1);
        // Smooth ramps on both upwind sides, where minmod gives a real slope.
        add_row(32'h0100_0000, 32'h0200_0000, 32'h0300_0000, 32'h0400_0000,
                32'h0500_0000, ONE_Q / 2, 1'b0, '0, 1'b0);
        add_row(32'h0100_0000, 32'h0200_0000, 32'h0300_0000, 32'h0400_0000,
                32'h0500_0000, -ONE_Q / 2, 1'b0, '0, 1'b0);
        add_row(32'h0900_0000, 32'h0700_0000, 32'h0400_0000, 32'h0200_0000,
                32'h0100_0000, ONE_Q / 4, 1'b0, '0, 1'b0);
        add_row(32'h0900_0000, 32'h0700_0000, 32'h0400_0000, 32'h0200_0000,
                32'h0100_0000, -3 * ONE_Q / 4, 1'b0, '0, 1'b0);
        // A peak and a valley: the differences disagree and the slope is zero.
        add_row(32'h0100_0000, 32'h0500_0000, 32'h0900_0000, 32'h0500_0000,
                32'h0100_0000, 19661, 1'b0, '0, 1'b0);
        add_row(32'h0900_0000, 32'h0500_0000, 32'h0100_0000, 32'h0500_0000,
                32'h0900_0000, -19661, 1'b0, '0, 1'b0);
        // A zero difference on one side also kills the slope.
        add_row(32'h0700_0000, 32'h0700_0000, 32'h0700_0000, 32'h0900_0000,
                32'h0C00_0000, 39322, 1'b0, '0, 1'b0);
        // Very uneven differences: the smaller one must win.
        add_row('0, 32'h0000_0100, 32'h0001_0000, 32'h0100_0000, VMAX, 58982, 1'b0, '0, 1'b0);
        add_row(VMAX, 32'h0100_0000, 32'h0001_0000, 32'h0000_0100, '0, -58982, 1'b0, '0, 1'b0);
        // Exact halves in the update, rounded away from zero.
        add_row(32'd5, 32'd5, 32'd6, 32'd6, 32'd6, ONE_Q / 2, 1'b0, '0, 1'b0);
        add_row(32'd6, 32'd6, 32'd6, 32'd5, 32'd5, -ONE_Q / 2, 1'b0, '0, 1'b0);
        // The smallest courant magnitudes on either side of zero.
        add_row(32'h1000_0000, 32'h2000_0000, 32'h3000_0000, 32'h5000_0000,
                32'h8000_0000, 1, 1'b0, '0, 1'b0);
        add_row(32'h1000_0000, 32'h2000_0000, 32'h3000_0000, 32'h5000_0000,
                32'h8000_0000, -1, 1'b0, '0, 1'b0);
        // Beyond one the limiter factor is negative and is used as it is.
        add_row(32'h0100_0000, 32'h0300_0000, 32'h0600_0000, 32'h0A00_0000,
                32'h0F00_0000, 3 * ONE_Q / 2, 1'b0, '0, 1'b0);
        add_row(32'h0F00_0000, 32'h0A00_0000, 32'h0600_0000, 32'h0300_0000,
                32'h0100_0000, -3 * ONE_Q / 2, 1'b0, '0, 1'b0);
        add_row(VMAX, VMAX, '0, VMAX, VMAX, ONE_Q / 2, 1'b0, '0, 1'b0);
        add_row(32'hDEAD_BEEF, 32'h0123_4567, 32'h89AB_CDEF, 32'h7654_3210,
                32'hFEDC_BA98, -ONE_Q, 1'b0, '0, 1'b0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        burst_left = 0;
        for (int i = 0; i < directed_rows.size() + RANDOM_ITEMS; i++)
        begin
            // Gaps between bursts; about a third of the bursts follow without one.
            if (burst_left == 0)
            begin
                gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            if (i < directed_rows.size())
            begin
                offer_request(directed_rows[i].fl, directed_rows[i].l, directed_rows[i].c0,
                              directed_rows[i].r, directed_rows[i].fr, directed_rows[i].cr,
                              directed_rows[i].typed, directed_rows[i].nv,
                              directed_rows[i].sat);
                directed_count++;
            end
            else
            begin
                draw_window(fl, l, c0, r, fr, cr);
                offer_request(fl, l, c0, r, fr, cr, 1'b0, '0, 1'b0);
            end
        end
        in_valid <= 1'b0;

        // Let the pipeline drain, then keep the clock running so that any stray result shows.
        while (pending_updates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d requests (%0d from the directed table), %0d results checked",
                 accepted_in, directed_count, checked_out);
        $display("summary: %0d results clamped, one long output hold-off, %0d mismatches",
                 clamped_out, error_count);
        if (error_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== minmod_flux_limited_advection_core.f =====
+incdir+sv
sv/mfa_pkg.sv
sv/mfa_slope.sv
sv/minmod_flux_limited_advection_core.sv
tb/sv/tb.sv
